// ===== rtl/cdq_pkg.sv =====
package cdq_pkg;

	// Default sizes of the queue.
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Command codes on the input channel.
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_REAR   = 3'd3;
	localparam logic [2:0] CMD_NOP        = 3'd4;

	// Status codes on the output channel.
	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_PUSH_FULL  = 2'd1;
	localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

	// Per-cycle orders broadcast to every cell of the row.
	typedef struct packed {
		logic shift_up;    // push at the front: every word moves one cell away from cell 0
		logic shift_down;  // pop at the front: every word moves one cell towards cell 0
		logic push_rear;   // push at the rear: the cell just past the tail takes the word
	} cdq_ctrl_t;

endpackage

// ===== rtl/cdq_cell.sv =====
module cdq_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_WIDTH  = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cdq_pkg::cdq_ctrl_t    ctrl,
	input  logic [CNT_WIDTH-1:0]  cnt,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	input  logic [DATA_WIDTH-1:0] push_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] tail_data
);
	import cdq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic                  is_next_free;
	logic                  is_tail;

	// Position of this cell relative to the current fill level.
	assign is_next_free = (cnt == CNT_WIDTH'(INDEX));
	assign is_tail      = (cnt == CNT_WIDTH'(INDEX + 1));

	// The word moves with its neighbours on front operations and is written
	// in place when a rear push lands on this cell; otherwise it is held.
	always_ff @(posedge clk) begin
		priority if (ctrl.shift_up) begin
			data_q <= prev_data;
		end else if (ctrl.shift_down) begin
			data_q <= next_data;
		end else if (ctrl.push_rear && is_next_free) begin
			data_q <= push_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data      = data_q;
	// Only the tail cell contributes to the rear word.
	assign tail_data = is_tail ? data_q : '0;

endmodule

// ===== rtl/circular_deque_core.sv =====
// Double-ended queue of DEPTH words of DATA_WIDTH bits, held in a row of cells with the
// front word always in cell 0. Each input transaction carries one command (push front,
// push rear, pop front, pop rear or no operation) and yields exactly one output
// transaction with the status, the popped word, the front and rear words, the count and
// the empty and full flags. A push into a full queue or a pop from an empty queue is
// refused with a status code and leaves the queue as it was. The cell row is updated at
// the edge that accepts a command, and the output register then reads the new front and
// rear words from the row once it is free or the output side is ready. A new command is
// accepted as soon as the previous result has entered the output register.
module circular_deque_core #(
	parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
	localparam int CNT_WIDTH = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            command,
	input  logic [DATA_WIDTH-1:0] data_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [DATA_WIDTH-1:0] popped_value,
	output logic [DATA_WIDTH-1:0] front_value,
	output logic [DATA_WIDTH-1:0] rear_value,
	output logic [CNT_WIDTH-1:0]  count,
	output logic                  is_empty,
	output logic                  is_full
);
	import cdq_pkg::*;

	logic [CNT_WIDTH-1:0]  cnt_q;
	logic                  pend_q;
	logic [1:0]            status_s1;
	logic [DATA_WIDTH-1:0] popped_s1;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [DATA_WIDTH-1:0] popped_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] rear_q;
	logic [CNT_WIDTH-1:0]  count_q;
	logic                  empty_out_q;
	logic                  full_out_q;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] tail_part [DEPTH];
	logic [DATA_WIDTH-1:0] rear_sel;
	cdq_ctrl_t             ctrl;
	logic                  accept;
	logic                  capture;
	logic                  q_empty;
	logic                  q_full;
	logic                  is_push;
	logic                  is_pop;
	logic [1:0]            status_d;
	logic [DATA_WIDTH-1:0] popped_d;

	// Handshake and the state of the queue before the current command.
	assign in_ready = !pend_q;
	assign accept   = in_valid && in_ready;
	assign capture  = pend_q && (!out_valid_q || out_ready);
	assign q_empty  = (cnt_q == '0);
	assign q_full   = (cnt_q == CNT_WIDTH'(DEPTH));
	assign is_push  = (command == CMD_PUSH_FRONT) || (command == CMD_PUSH_REAR);
	assign is_pop   = (command == CMD_POP_FRONT) || (command == CMD_POP_REAR);

	// Orders to the cell row; refused commands leave the row untouched.
	always_comb begin
		ctrl.shift_up   = accept && (command == CMD_PUSH_FRONT) && !q_full;
		ctrl.push_rear  = accept && (command == CMD_PUSH_REAR) && !q_full;
		ctrl.shift_down = accept && (command == CMD_POP_FRONT) && !q_empty;
	end

	// Row of cells; cell 0 holds the front word.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_word;
		logic [DATA_WIDTH-1:0] next_word;

		if (i == 0) begin : g_first
			assign prev_word = data_in;
		end else begin : g_mid_prev
			assign prev_word = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_word = cell_data[i];
		end else begin : g_mid_next
			assign next_word = cell_data[i+1];
		end

		cdq_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_WIDTH  (CNT_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.cnt       (cnt_q),
			.prev_data (prev_word),
			.next_data (next_word),
			.push_data (data_in),
			.data      (cell_data[i]),
			.tail_data (tail_part[i])
		);
	end

	// At most one cell flags itself as the tail, so the rear word is an OR over the row.
	always_comb begin
		rear_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_sel = rear_sel | tail_part[i];
		end
	end

	// Status and popped word of the command being accepted.
	always_comb begin
		status_d = ST_DONE;
		popped_d = '0;
		if (is_push && q_full) begin
			status_d = ST_PUSH_FULL;
		end else if (is_pop && q_empty) begin
			status_d = ST_POP_EMPTY;
		end else if (command == CMD_POP_FRONT) begin
			popped_d = cell_data[0];
		end else if (command == CMD_POP_REAR) begin
			popped_d = rear_sel;
		end
	end

	// Fill level and the per-command result that waits for the row to settle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if ((ctrl.shift_up || ctrl.push_rear)) begin
				cnt_q <= cnt_q + CNT_WIDTH'(1);
			end else if (ctrl.shift_down || (accept && (command == CMD_POP_REAR) && !q_empty)) begin
				cnt_q <= cnt_q - CNT_WIDTH'(1);
			end
			if (accept) begin
				pend_q <= 1'b1;
			end else if (capture) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			popped_s1 <= popped_d;
		end
	end

	// Output register, loaded from the updated row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (capture) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			status_q    <= status_s1;
			popped_q    <= popped_s1;
			front_q     <= q_empty ? '0 : cell_data[0];
			rear_q      <= rear_sel;
			count_q     <= cnt_q;
			empty_out_q <= q_empty;
			full_out_q  <= q_full;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign popped_value = popped_q;
	assign front_value  = front_q;
	assign rear_value   = rear_q;
	assign count        = count_q;
	assign is_empty     = empty_out_q;
	assign is_full      = full_out_q;

	// The fill level never passes the size of the row.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_WIDTH'(DEPTH))
		else $error("deque fill level beyond depth");

	// An accepted command always leaves a result pending.
	a_accept_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pend_q)
		else $error("accepted command left no pending result");

	// A successful front push puts the pushed word in cell 0.
	a_push_front: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift_up |=> (cell_data[0] == $past(data_in)))
		else $error("front push did not land in cell 0");

	// A result enters the output register only after its command was applied.
	a_capture_valid: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> out_valid_q && !pend_q)
		else $error("captured result not presented");

endmodule

// ===== dv/circular_deque_core_tb.sv =====
module circular_deque_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int DW    = DATA_WIDTH_DEF;
	localparam int CW    = $clog2(DEPTH + 1);

	// Codes 5 to 7 are unused and must behave as no operation.
	localparam logic [2:0] CMD_MAX_CODE = 3'd7;

	localparam int RANDOM_COMMANDS = 650;

	typedef struct {
		logic [1:0]    status;
		logic [DW-1:0] popped;
		logic [DW-1:0] front;
		logic [DW-1:0] rear;
		logic [CW-1:0] count;
		logic          empty;
		logic          full;
	} deque_result_t;

	// Mirror of the deque: it tracks the ring contents and holds the
	// results still owed by the block, oldest first.
	class deque_mirror;
		logic [DW-1:0] slots [DEPTH];
		int            head;
		int            fill;
		deque_result_t owed [$];
		int            errors;

		function new();
			head   = 0;
			fill   = 0;
			errors = 0;
		endfunction

		task report_mismatch(input string what);
			$display("%0t ns: mismatch: %s", $time, what);
			errors++;
		endtask

		// Apply one accepted command and queue the result it must produce.
		function void note_command(input logic [2:0] cmd, input logic [DW-1:0] word);
			deque_result_t r;
			r.status = ST_DONE;
			r.popped = '0;
			r.front  = '0;
			r.rear   = '0;
			case (cmd)
				CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
					if (fill == DEPTH) begin
						r.status = ST_PUSH_FULL;
					end else if (cmd == CMD_PUSH_FRONT) begin
						head = (head + DEPTH - 1) % DEPTH;
						slots[head] = word;
						fill++;
					end else begin
						slots[(head + fill) % DEPTH] = word;
						fill++;
					end
				end
				CMD_POP_FRONT, CMD_POP_REAR: begin
					if (fill == 0) begin
						r.status = ST_POP_EMPTY;
					end else if (cmd == CMD_POP_FRONT) begin
						r.popped = slots[head];
						head = (head + 1) % DEPTH;
						fill--;
					end else begin
						r.popped = slots[(head + fill - 1) % DEPTH];
						fill--;
					end
				end
				default: begin
					// No operation, including the unused codes.
				end
			endcase
			if (fill != 0) begin
				r.front = slots[head];
				r.rear  = slots[(head + fill - 1) % DEPTH];
			end
			r.count = CW'(fill);
			r.empty = (fill == 0);
			r.full  = (fill == DEPTH);
			owed.push_back(r);
		endfunction

		// Compare one accepted result with the oldest owed one.
		task check_result(input deque_result_t got);
			deque_result_t want;
			if (owed.size() == 0) begin
				report_mismatch("result transaction with nothing outstanding");
			end else begin
				want = owed.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
				if (got.popped !== want.popped)
					report_mismatch($sformatf("popped_value %h, wanted %h",
						got.popped, want.popped));
				if (got.front !== want.front)
					report_mismatch($sformatf("front_value %h, wanted %h", got.front, want.front));
				if (got.rear !== want.rear)
					report_mismatch($sformatf("rear_value %h, wanted %h", got.rear, want.rear));
				if (got.count !== want.count)
					report_mismatch($sformatf("count %0d, wanted %0d", got.count, want.count));
				if (got.empty !== want.empty)
					report_mismatch($sformatf("is_empty %b, wanted %b", got.empty, want.empty));
				if (got.full !== want.full)
					report_mismatch($sformatf("is_full %b, wanted %b", got.full, want.full));
			end
		endtask
	endclass

	logic          clk;
	logic          arst_n       = 1'b0;
	logic          in_valid     = 1'b0;
	logic          in_ready;
	logic [2:0]    command      = CMD_NOP;
	logic [DW-1:0] data_in      = '0;
	logic          out_valid;
	logic          out_ready    = 1'b0;
	logic [1:0]    status;
	logic [DW-1:0] popped_value;
	logic [DW-1:0] front_value;
	logic [DW-1:0] rear_value;
	logic [CW-1:0] count;
	logic          is_empty;
	logic          is_full;

	deque_mirror mirror;
	bit          no_idle = 1'b0;
	int          level   = 0;

	circular_deque_core #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.data_in(data_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.popped_value(popped_value),
		.front_value(front_value),
		.rear_value(rear_value),
		.count(count),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The result side stalls about 30 percent of the time, except while no_idle is set.
	always @(posedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= 30);
	end

	// Watch both channels; the values read here are those from before the edge.
	always @(posedge clk) begin
		deque_result_t got;
		if (arst_n) begin
			if (in_valid && in_ready)
				mirror.note_command(command, data_in);
			if (out_valid && out_ready) begin
				got.status = status;
				got.popped = popped_value;
				got.front  = front_value;
				got.rear   = rear_value;
				got.count  = count;
				got.empty  = is_empty;
				got.full   = is_full;
				mirror.check_result(got);
			end
		end
	end

	// Offer one command transaction, with a random idle gap before it, and
	// return at the edge that accepts it.
	task automatic send_command(input logic [2:0] cmd, input logic [DW-1:0] word);
		int gap;
		gap = 0;
		if (!no_idle) begin
			while ($urandom_range(99) < 30)
				gap++;
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		data_in  <= word;
		do @(posedge clk); while (!in_ready);
		// Keep a rough level so that the random part can steer between empty and full.
		if ((cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) && level < DEPTH)
			level++;
		else if ((cmd == CMD_POP_FRONT || cmd == CMD_POP_REAR) && level > 0)
			level--;
	endtask

	function automatic logic [DW-1:0] random_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return DW'($urandom);
		endcase
	endfunction

	// Main sequence: reset, directed commands, then random walks between empty and full.
	initial begin
		bit          filling;
		int          pick;
		logic [2:0]  cmd;
		mirror = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rejected pops, no operation and unused codes on an empty deque.
		send_command(CMD_POP_FRONT, random_word());
		send_command(CMD_POP_REAR, random_word());
		send_command(CMD_NOP, '1);
		send_command(CMD_NOP + 3'd1, random_word());
		send_command(CMD_MAX_CODE, random_word());
		// Extreme words at both ends, fill to the brim from both sides, then push into the full deque and pop from both ends.
		send_command(CMD_PUSH_FRONT, '0);
		send_command(CMD_PUSH_REAR, '1);
		for (int i = 0; i < DEPTH - 2; i++) begin
			send_command((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR,
				(i % 3 == 0) ? {(DW/2){2'b10}} : DW'($urandom));
		end
		send_command(CMD_PUSH_FRONT, random_word());
		send_command(CMD_PUSH_REAR, random_word());
		send_command(CMD_POP_FRONT, random_word());
		send_command(CMD_POP_REAR, random_word());

		// Random part: mostly pushes while filling and pops while draining,
		// with a few commands that do nothing.
		filling = 1'b0;
		for (int n = 0; n < RANDOM_COMMANDS; n++) begin
			no_idle = (n >= 300 && n < 420);
			if (level == DEPTH && $urandom_range(3) == 0)
				filling = 1'b0;
			else if (level == 0 && $urandom_range(3) == 0)
				filling = 1'b1;
			else if ($urandom_range(49) == 0)
				filling = !filling;
			pick = $urandom_range(99);
			if (pick < 6) begin
				cmd = 3'($urandom_range(CMD_MAX_CODE, CMD_NOP));
			end else if ((pick < 76) == filling) begin
				cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
			end else begin
				cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_REAR;
			end
			send_command(cmd, random_word());
		end
		in_valid <= 1'b0;
		no_idle = 1'b0;

		// Let the monitor note the last command and drain the outstanding
		// results, then let the bench idle before the verdict.
		@(posedge clk);
		while (mirror.owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mirror.errors == 0) begin
			$display("circular_deque_core_tb: PASS");
		end else begin
			$display("circular_deque_core_tb: FAIL");
		end
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#2_000_000;
		$display("circular_deque_core_tb: FAIL");
		$finish;
	end

endmodule

// ===== circular_deque_core.f =====
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque_core.sv
dv/circular_deque_core_tb.sv
